>>> sv/rtt_pkg.sv
// shared types, constants and helpers for the replacement template tokenizer
// used by every module of the block; depends on nothing
package rtt_pkg;

  localparam int MAX_DIGITS     = 8;
  localparam int MAX_GROUPS_DEF = 64;

  localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int DIDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int SUB_W   = $clog2(MAX_DIGITS + 2);
  localparam int NOPS    = 4;
  localparam int NOPS_W  = $clog2(NOPS + 1);
  localparam int OPIDX_W = $clog2(NOPS);
  localparam int QDEPTH  = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_COPY    = 1'b1;

  localparam logic [1:0] KIND_LIT = 2'd0;
  localparam logic [1:0] KIND_REF = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_TAB    = 8'd9;

  typedef enum logic [1:0] {
    OP_LIT    = 2'd0,
    OP_REF    = 2'd1,
    OP_REPLAY = 2'd2,
    OP_END    = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] lit;
  } op_t;

  typedef struct packed {
    op_t [NOPS-1:0]                ops;
    logic [NOPS_W-1:0]             n_ops;
    logic [5:0]                    group_index;
    logic [MAX_DIGITS-1:0][3:0]    digits;
    logic [DCNT_W-1:0]             dcnt;
    logic                          lost;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  typedef struct packed {
    logic [7:0] template_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] literal;
    logic [5:0] group_index;
    logic       digits_lost;
    logic       run_end;
  } out_t;

  function automatic op_t mk_op(op_kind_t k, logic [7:0] v);
    op_t o;
    o.kind = k;
    o.lit  = v;
    return o;
  endfunction

endpackage

>>> sv/replacement_template_tokenizer.sv
// top level of the replacement template tokenizer
// instantiates rtt_front, rtt_queue and rtt_back; uses rtt_pkg
//
// template bytes enter through push/full/in_data, one item per accepted edge;
// the last_byte flag closes the template and produces an end token
// tokens leave through empty/pop/out_data in order; run_end marks the last
// token that an input byte caused
// config writes go through cfg_valid/cfg_index/cfg_data, cfg_ready is always
// high; index 0 is group_count, index 1 is raw_copy
// a token passes from its accepted byte through the command queue into the output register
// throughput: the front takes one byte per cycle while full is low; the back
// sequencer emits one token per cycle while the receiver keeps up, so a byte that
// yields k tokens (up to 12 on an unclosed brace run) holds the back until all k are out,
// while the two-entry command queue lets the front run ahead until it fills and full rises
// a stalled receiver (pop low) holds the current token and backs up through
// the queue to full
// reset clears tokenizer state, config registers, the command queue pointers and
// the output valid flag; the digit buffer and output data are left as is and
// only read after being written
module replacement_template_tokenizer import rtt_pkg::*; #(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_t                   in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  rtt_front #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_wr      (q_wr)
  );

  rtt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  rtt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (q_rd),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> sv/rtt_front.sv
// front end: accepts template bytes, holds the tokenizer state and config registers
// and turns each item into at most one command for the back end; uses rtt_pkg
module rtt_front import rtt_pkg::*; #(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  in_t                   in_data,
  input  logic                  full,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output q_wr_t                 q_wr
);

  localparam int AW  = $clog2(MAX_GROUPS + 1);
  localparam int ACW = AW + 4;
  localparam int XW  = (AW > 7) ? AW : 7;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_BSLASH = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_DOLLAR = 5'b01000,
    PH_BRACE  = 5'b10000
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [AW-1:0]              acc_r, acc_nxt;
  logic [DCNT_W-1:0]          dcnt_r, dcnt_nxt;
  logic                       lost_r, lost_nxt;
  logic [MAX_DIGITS-1:0][3:0] dbuf_r, dbuf_nxt;
  logic [6:0]                 gc_r;
  logic                       raw_r;

  logic [7:0]     b;
  logic           last;
  logic           accept;
  logic           is_dig;
  logic [3:0]     dval;
  logic [7:0]     esc;
  logic [AW-1:0]  acc_base;
  logic [ACW-1:0] acc_prod;
  logic [AW-1:0]  acc_step;
  logic [XW-1:0]  acc_x;
  logic           idle_take;
  logic [NOPS_W-1:0] n;
  cmd_t           cmd;

  function automatic logic ref_ok(logic [AW-1:0] a, logic [6:0] gc);
    return (XW'(a) < XW'(gc)) && (a < AW'(MAX_GROUPS));
  endfunction

  assign b      = in_data.template_byte;
  assign last   = in_data.last_byte;
  assign accept = push && !full;
  assign is_dig = b inside {[CH_ZERO:CH_NINE]};
  assign dval   = b[3:0];

  always_comb begin
    case (b)
      CH_N:    esc = CH_LF;
      CH_R:    esc = CH_CR;
      CH_T:    esc = CH_TAB;
      default: esc = b;
    endcase
  end

  // index = index * 10 + digit, saturating
  assign acc_base = (phase_r == PH_DIGITS || phase_r == PH_BRACE) ? acc_r : '0;
  assign acc_prod = (ACW'(acc_base) << 3) + (ACW'(acc_base) << 1) + ACW'(dval);
  assign acc_step = (acc_prod > ACW'(MAX_GROUPS)) ? AW'(MAX_GROUPS) : acc_prod[AW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    lost_nxt  = lost_r;
    dbuf_nxt  = dbuf_r;
    cmd       = '0;
    n         = '0;
    idle_take = 1'b0;
    acc_x     = '0;
    if (raw_r) begin
      cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_LIT, b);
      n = n + NOPS_W'(1);
      if (last) begin
        cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_END, 8'h00);
        n = n + NOPS_W'(1);
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        dcnt_nxt  = '0;
        lost_nxt  = 1'b0;
      end
    end else begin
      case (phase_r)
        PH_BSLASH: begin
          if (is_dig) begin
            acc_nxt   = acc_step;
            phase_nxt = PH_DIGITS;
          end else begin
            cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_LIT, esc);
            n = n + NOPS_W'(1);
            phase_nxt = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            acc_nxt = acc_step;
          end else begin
            if (ref_ok(acc_nxt, gc_r)) begin
              acc_x = XW'(acc_nxt);
              cmd.group_index = acc_x[5:0];
              cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_REF, 8'h00);
              n = n + NOPS_W'(1);
            end
            acc_nxt   = '0;
            idle_take = 1'b1;
          end
        end
        PH_DOLLAR: begin
          if (b == CH_LBRACE) begin
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            lost_nxt  = 1'b0;
            phase_nxt = PH_BRACE;
          end else if (is_dig) begin
            acc_nxt   = acc_step;
            phase_nxt = PH_DIGITS;
          end else begin
            cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_LIT, CH_DOLLAR);
            n = n + NOPS_W'(1);
            idle_take = 1'b1;
          end
        end
        PH_BRACE: begin
          if (is_dig) begin
            acc_nxt = acc_step;
            if (dcnt_nxt < DCNT_W'(MAX_DIGITS)) begin
              dbuf_nxt[dcnt_nxt[DIDX_W-1:0]] = dval;
              dcnt_nxt = dcnt_nxt + DCNT_W'(1);
            end else begin
              lost_nxt = 1'b1;
            end
          end else if (b == CH_RBRACE) begin
            if (ref_ok(acc_nxt, gc_r)) begin
              acc_x = XW'(acc_nxt);
              cmd.group_index = acc_x[5:0];
              cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_REF, 8'h00);
              n = n + NOPS_W'(1);
            end
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            lost_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end else begin
            cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_REPLAY, 8'h00);
            n = n + NOPS_W'(1);
            cmd.dcnt  = dcnt_nxt;
            cmd.lost  = lost_nxt;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            lost_nxt  = 1'b0;
            idle_take = 1'b1;
          end
        end
        default: idle_take = 1'b1;
      endcase

      if (idle_take) begin
        if (b == CH_BSLASH) begin
          phase_nxt = PH_BSLASH;
        end else if (b == CH_DOLLAR) begin
          phase_nxt = PH_DOLLAR;
        end else begin
          phase_nxt = PH_IDLE;
          cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_LIT, b);
          n = n + NOPS_W'(1);
        end
      end

      // flush whatever is pending at the end of the template
      if (last) begin
        case (phase_nxt)
          PH_BSLASH: begin
            cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_LIT, CH_BSLASH);
            n = n + NOPS_W'(1);
          end
          PH_DOLLAR: begin
            cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_LIT, CH_DOLLAR);
            n = n + NOPS_W'(1);
          end
          PH_DIGITS: begin
            if (ref_ok(acc_nxt, gc_r)) begin
              acc_x = XW'(acc_nxt);
              cmd.group_index = acc_x[5:0];
              cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_REF, 8'h00);
              n = n + NOPS_W'(1);
            end
          end
          PH_BRACE: begin
            cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_REPLAY, 8'h00);
            n = n + NOPS_W'(1);
            cmd.dcnt = dcnt_nxt;
            cmd.lost = lost_nxt;
          end
          default: ;
        endcase
        cmd.ops[n[OPIDX_W-1:0]] = mk_op(OP_END, 8'h00);
        n = n + NOPS_W'(1);
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        dcnt_nxt  = '0;
        lost_nxt  = 1'b0;
      end
    end
    cmd.digits = dbuf_nxt;
    cmd.n_ops  = n;
  end

  assign q_wr.push = accept && (n != '0);
  assign q_wr.cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      dcnt_r  <= '0;
      lost_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      lost_r  <= lost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dbuf_r <= dbuf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r  <= '0;
      raw_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GROUP_COUNT: gc_r  <= cfg_data;
        REG_RAW_COPY:    raw_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/rtt_queue.sv
// short command queue between front and back end
// uses rtt_pkg for the command type and depth
module rtt_queue import rtt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t wr,
  output logic  full,
  output q_rd_t rd,
  input  logic  pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t            mem_r [QDEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [PW:0]     cnt_r;

  assign full     = (cnt_r == (PW + 1)'(QDEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.cmd   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wptr_r] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr.push) begin
        wptr_r <= (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      case ({wr.push, pop})
        2'b10:   cnt_r <= cnt_r + (PW + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/rtt_back.sv
// back end: steps through the head command into the output register, one result
// per cycle while that register is free or being popped; uses rtt_pkg
module rtt_back import rtt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_rd_t rd,
  output logic  q_pop,
  output logic  empty,
  input  logic  pop,
  output out_t  out_data
);

  logic [OPIDX_W-1:0] pos_r, pos_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [SUB_W-1:0]   dig_sel;
  logic [3:0]         digit;
  op_t                cur;
  out_t               res;
  out_t               out_r;
  logic               out_v_r;
  logic               op_done, cmd_done, emit;

  assign cur     = rd.cmd.ops[pos_r];
  assign dig_sel = sub_r - SUB_W'(2);
  assign digit   = rd.cmd.digits[dig_sel[DIDX_W-1:0]];

  assign op_done  = (cur.kind != OP_REPLAY) ||
                    (sub_r == SUB_W'(rd.cmd.dcnt) + SUB_W'(1));
  assign cmd_done = op_done && (NOPS_W'(pos_r) == rd.cmd.n_ops - NOPS_W'(1));
  assign emit     = rd.valid && (!out_v_r || pop);
  assign q_pop    = emit && cmd_done;

  always_comb begin
    res = '0;
    case (cur.kind)
      OP_LIT: begin
        res.kind    = KIND_LIT;
        res.literal = cur.lit;
      end
      OP_REF: begin
        res.kind        = KIND_REF;
        res.group_index = rd.cmd.group_index;
      end
      OP_REPLAY: begin
        res.kind        = KIND_LIT;
        res.digits_lost = rd.cmd.lost;
        if (sub_r == '0) begin
          res.literal = CH_DOLLAR;
        end else if (sub_r == SUB_W'(1)) begin
          res.literal = CH_LBRACE;
        end else begin
          res.literal = CH_ZERO | {4'b0000, digit};
        end
      end
      OP_END: res.kind = KIND_END;
      default: res = '0;
    endcase
    res.run_end = cmd_done;
  end

  always_comb begin
    pos_nxt = pos_r;
    sub_nxt = sub_r;
    if (emit) begin
      if (cmd_done) begin
        pos_nxt = '0;
        sub_nxt = '0;
      end else if (op_done) begin
        pos_nxt = pos_r + OPIDX_W'(1);
        sub_nxt = '0;
      end else begin
        sub_nxt = sub_r + SUB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sub_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sub_r <= sub_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign empty    = !out_v_r;
  assign out_data = out_r;

endmodule

>>> sv/rtt_checker.sv
// port-level checks for the replacement template tokenizer
// bound to replacement_template_tokenizer; uses rtt_pkg
module rtt_checker import rtt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t out_data
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queue not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting item changed");

  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.kind == KIND_END |-> out_data.run_end && out_data.group_index == 6'd0)
    else $error("end token malformed");

  a_non_literal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.kind != KIND_LIT |-> out_data.literal == 8'h00 && !out_data.digits_lost)
    else $error("literal fields set on a non-literal item");

endmodule

bind replacement_template_tokenizer rtt_checker u_chk (.*);

>>> tb/sv/replacement_template_tokenizer_test.sv
`timescale 1ns / 100ps
// self-checking testbench for replacement_template_tokenizer: queue-style driver and
// monitor with random stalls, a token predictor kept in step with each accepted item
// depends on rtt_pkg and the replacement_template_tokenizer rtl only
module replacement_template_tokenizer_test;
  import rtt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    TK_IDLE,
    TK_BSLASH,
    TK_BS_DIGITS,
    TK_DOLLAR,
    TK_DOL_DIGITS,
    TK_BRACE
  } tk_phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_t                   in_data = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // tokenizer state and register copies used for prediction
  tk_phase_t   tk_phase = TK_IDLE;
  int unsigned grp_acc = 0;
  logic [3:0]  brace_digits [MAX_DIGITS];
  int unsigned brace_cnt = 0;
  logic        brace_lost = 1'b0;
  logic [6:0]  cfg_groups = '0;
  logic        cfg_raw = 1'b0;

  in_t         pending[$];
  out_t        step_toks[$];
  out_t        token_q[$];
  out_t        want_tok;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned pop_wait = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;

  replacement_template_tokenizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void add_tok(logic [1:0] k, logic [7:0] lit, logic [5:0] gi, logic lost);
    out_t t;
    t.kind        = k;
    t.literal     = lit;
    t.group_index = gi;
    t.digits_lost = lost;
    t.run_end     = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic bit is_dec(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // index saturates at the group limit
  function automatic void add_digit(logic [7:0] b);
    int unsigned v;
    v = grp_acc * 10 + (b - CH_ZERO);
    grp_acc = (v > MAX_GROUPS_DEF) ? MAX_GROUPS_DEF : v;
  endfunction

  function automatic void close_ref();
    if (grp_acc < cfg_groups && grp_acc < MAX_GROUPS_DEF) begin
      add_tok(KIND_REF, '0, 6'(grp_acc), 1'b0);
    end
    grp_acc = 0;
  endfunction

  // unclosed brace run comes back as literals
  function automatic void flush_brace();
    add_tok(KIND_LIT, CH_DOLLAR, '0, brace_lost);
    add_tok(KIND_LIT, CH_LBRACE, '0, brace_lost);
    for (int k = 0; k < brace_cnt; k++) begin
      add_tok(KIND_LIT, CH_ZERO + brace_digits[k], '0, brace_lost);
    end
    brace_cnt  = 0;
    brace_lost = 1'b0;
    grp_acc    = 0;
  endfunction

  function automatic void idle_byte(logic [7:0] b);
    if (b == CH_BSLASH) begin
      tk_phase = TK_BSLASH;
    end else if (b == CH_DOLLAR) begin
      tk_phase = TK_DOLLAR;
    end else begin
      tk_phase = TK_IDLE;
      add_tok(KIND_LIT, b, '0, 1'b0);
    end
  endfunction

  function automatic void clear_tok_state();
    tk_phase   = TK_IDLE;
    grp_acc    = 0;
    brace_cnt  = 0;
    brace_lost = 1'b0;
  endfunction

  function automatic void tokenize_byte(in_t it);
    logic [7:0] b;
    out_t t;
    b = it.template_byte;
    step_toks.delete();
    if (cfg_raw) begin
      add_tok(KIND_LIT, b, '0, 1'b0);
      if (it.last_byte) begin
        add_tok(KIND_END, '0, '0, 1'b0);
        clear_tok_state();
      end
    end else begin
      case (tk_phase)
        TK_BSLASH: begin
          if (is_dec(b)) begin
            grp_acc = 0;
            add_digit(b);
            tk_phase = TK_BS_DIGITS;
          end else begin
            tk_phase = TK_IDLE;
            if (b == CH_N) add_tok(KIND_LIT, CH_LF, '0, 1'b0);
            else if (b == CH_R) add_tok(KIND_LIT, CH_CR, '0, 1'b0);
            else if (b == CH_T) add_tok(KIND_LIT, CH_TAB, '0, 1'b0);
            else add_tok(KIND_LIT, b, '0, 1'b0);
          end
        end
        TK_BS_DIGITS, TK_DOL_DIGITS: begin
          if (is_dec(b)) begin
            add_digit(b);
          end else begin
            close_ref();
            idle_byte(b);
          end
        end
        TK_DOLLAR: begin
          if (b == CH_LBRACE) begin
            grp_acc    = 0;
            brace_cnt  = 0;
            brace_lost = 1'b0;
            tk_phase   = TK_BRACE;
          end else if (is_dec(b)) begin
            grp_acc = 0;
            add_digit(b);
            tk_phase = TK_DOL_DIGITS;
          end else begin
            add_tok(KIND_LIT, CH_DOLLAR, '0, 1'b0);
            idle_byte(b);
          end
        end
        TK_BRACE: begin
          if (is_dec(b)) begin
            add_digit(b);
            if (brace_cnt < MAX_DIGITS) begin
              brace_digits[brace_cnt] = 4'(b - CH_ZERO);
              brace_cnt++;
            end else begin
              brace_lost = 1'b1;
            end
          end else if (b == CH_RBRACE) begin
            close_ref();
            brace_cnt  = 0;
            brace_lost = 1'b0;
            tk_phase   = TK_IDLE;
          end else begin
            flush_brace();
            idle_byte(b);
          end
        end
        default: idle_byte(b);
      endcase
      if (it.last_byte) begin
        case (tk_phase)
          TK_BSLASH:                   add_tok(KIND_LIT, CH_BSLASH, '0, 1'b0);
          TK_DOLLAR:                   add_tok(KIND_LIT, CH_DOLLAR, '0, 1'b0);
          TK_BS_DIGITS, TK_DOL_DIGITS: close_ref();
          TK_BRACE:                    flush_brace();
          default: ;
        endcase
        add_tok(KIND_END, '0, '0, 1'b0);
        clear_tok_state();
      end
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.run_end = 1'b1;
      step_toks.push_back(t);
    end
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic last);
    in_t it;
    it.template_byte = b;
    it.last_byte     = last;
    pending.push_back(it);
  endfunction

  function automatic void add_text(string s, logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i], last_at_end && (i == s.len() - 1));
    end
  endfunction

  function automatic void add_digits(int unsigned lo, int unsigned hi);
    int unsigned n;
    n = $urandom_range(lo, hi);
    repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
  endfunction

  // mostly well formed escapes and references, some noise and broken runs
  function automatic void add_segment();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    case (sel)
      0, 1: add_byte(8'($urandom), 1'b0);
      2: begin
        add_byte(CH_BSLASH, 1'b0);
        case ($urandom_range(0, 3))
          0:       add_byte(CH_N, 1'b0);
          1:       add_byte(CH_R, 1'b0);
          2:       add_byte(CH_T, 1'b0);
          default: add_byte(8'($urandom), 1'b0);
        endcase
      end
      3, 4: begin
        add_byte(CH_BSLASH, 1'b0);
        add_digits(1, 4);
      end
      5, 6: begin
        add_byte(CH_DOLLAR, 1'b0);
        add_digits(1, 3);
      end
      7, 8: begin
        add_byte(CH_DOLLAR, 1'b0);
        add_byte(CH_LBRACE, 1'b0);
        add_digits(0, 3);
        add_byte(CH_RBRACE, 1'b0);
      end
      9: begin
        add_byte(CH_DOLLAR, 1'b0);
        add_byte(CH_LBRACE, 1'b0);
        add_digits(0, 11);
      end
      10: begin
        add_byte(CH_DOLLAR, 1'b0);
        add_byte(8'($urandom), 1'b0);
      end
      default: add_byte($urandom_range(0, 1) ? CH_BSLASH : CH_DOLLAR, 1'b0);
    endcase
  endfunction

  function automatic void fill_templates(int unsigned n_items);
    in_t it;
    while (pending.size() < n_items) begin
      repeat ($urandom_range(1, 6)) add_segment();
      it = pending.pop_back();
      it.last_byte = 1'b1;
      pending.push_back(it);
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GROUP_COUNT) cfg_groups = val;
    else cfg_raw = val[0];
  endtask

  task automatic set_config(logic [6:0] groups, logic raw, bit idle_tx, bit idle_rx);
    write_reg(REG_GROUP_COUNT, groups);
    write_reg(REG_RAW_COPY, 7'(raw));
    @(negedge clk);
    send_idle = idle_tx;
    recv_idle = idle_rx;
  endtask

  // sender holds off until every expected token is back, then a short settle
  task automatic drain();
    do @(negedge clk); while (pending.size() != 0 || push || token_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push    <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        tokenize_byte(in_data);
        send_gap = send_idle ? $urandom_range(0, 5) : 0;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (pending.size() > 0) begin
          in_data <= pending.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop     <= 1'b0;
      pop_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected token: kind %0d lit %h grp %0d lost %b end %b",
                     out_data.kind, out_data.literal, out_data.group_index,
                     out_data.digits_lost, out_data.run_end);
          end
        end else begin
          want_tok = token_q.pop_front();
          if (out_data.kind !== want_tok.kind || out_data.literal !== want_tok.literal ||
              out_data.group_index !== want_tok.group_index ||
              out_data.digits_lost !== want_tok.digits_lost ||
              out_data.run_end !== want_tok.run_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("token mismatch: expected kind %0d lit %h grp %0d lost %b end %b",
                       want_tok.kind, want_tok.literal, want_tok.group_index,
                       want_tok.digits_lost, want_tok.run_end);
              $display("                got      kind %0d lit %h grp %0d lost %b end %b",
                       out_data.kind, out_data.literal, out_data.group_index,
                       out_data.digits_lost, out_data.run_end);
            end
          end
        end
        pop_wait = recv_idle ? $urandom_range(0, 5) : 0;
      end else if (!pop && pop_wait > 0) begin
        pop_wait--;
      end
      pop <= (pop_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("replacement_template_tokenizer verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // escapes, all reference forms, empty and unclosed braces, lone trailing escape
    set_config(7'd64, 1'b0, 1'b1, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_text("\\n\\t\\r\\q\\1a$7${3}${}${4x$q\\", 1'b1);
    drain();

    set_config(7'd64, 1'b0, 1'b1, 1'b1);
    fill_templates(50);
    drain();

    set_config(7'd0, 1'b0, 1'b0, 1'b0);
    fill_templates(40);
    drain();

    // leave a brace run open across raw mode
    set_config(7'd127, 1'b0, 1'b1, 1'b0);
    fill_templates(50);
    add_text("${12", 1'b0);
    drain();

    set_config(7'd10, 1'b1, 1'b0, 1'b0);
    repeat (20) add_byte(8'($urandom), 1'b0);
    drain();

    set_config(7'd64, 1'b0, 1'b0, 1'b1);
    add_byte(CH_RBRACE, 1'b0);
    fill_templates(45);
    drain();

    set_config(7'd10, 1'b1, 1'b1, 1'b1);
    add_text("$1", 1'b0);
    fill_templates(35);
    drain();

    set_config(7'd1, 1'b0, 1'b1, 1'b1);
    fill_templates(40);
    drain();

    set_config(7'd37, 1'b0, 1'b1, 1'b1);
    fill_templates(50);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("replacement_template_tokenizer verification clean");
    end else begin
      $display("replacement_template_tokenizer verification failed");
    end
    $finish;
  end

endmodule
